// ===== src/sgrr_pkg.sv =====
// sgrr_pkg: shared types and constants of the saturated gyro rate recovery block
// used by sgrr_divsqrt and the top level; no dependencies

package sgrr_pkg;

    localparam int AXIS_W  = 18;   // spin axis component, |v| <= 1.0 in signed Q1.16
    localparam int LEVER_W = 19;
    localparam int LIMIT_W = 31;
    localparam int LEV_W   = 26;   // lever vector component
    localparam int D_W     = 24;   // projection b.a

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd786432;
    localparam logic signed [LEVER_W-1:0] LEVER_X_RESET = -19'sd1442;
    localparam logic signed [LEVER_W-1:0] LEVER_Y_RESET = -19'sd5571;
    localparam logic signed [LEVER_W-1:0] LEVER_Z_RESET = 19'sd3604;
    localparam logic signed [AXIS_W-1:0]  AXIS_ONE      = 18'sd65536;

    // register indexes
    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_LEVER_X = 2'd1;
    localparam logic [1:0] REG_LEVER_Y = 2'd2;
    localparam logic [1:0] REG_LEVER_Z = 2'd3;

    // axis codes
    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    // confidence codes
    localparam logic [1:0] CONF_MEASURED = 2'd0;
    localparam logic [1:0] CONF_RECON    = 2'd1;
    localparam logic [1:0] CONF_REJECT   = 2'd2;

    // iteration counts of the shift-subtract unit
    localparam logic [6:0] ITER_W2   = 7'd64;
    localparam logic [6:0] ITER_ROOT = 7'd32;
    localparam logic [6:0] ITER_NORM = 7'd17;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DOT  = 13'b0000000000010,
        S_LEV  = 13'b0000000000100,
        S_NUM  = 13'b0000000001000,
        S_CHK  = 13'b0000000010000,
        S_DIV  = 13'b0000000100000,
        S_OTH  = 13'b0000001000000,
        S_CMP  = 13'b0000010000000,
        S_ROOT = 13'b0000100000000,
        S_NSQ  = 13'b0001000000000,
        S_NRT  = 13'b0010000000000,
        S_NDIV = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [6:0]  iters;
        logic [65:0] rem_init;
        logic [63:0] feed;
        logic [63:0] divisor;
    } t_unit_cmd;

endpackage

// ===== src/sgrr_mult.sv =====
// sgrr_mult: shared 32 x 32 signed multiplier with registered product
// no dependencies

module sgrr_mult (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/sgrr_divsqrt.sv =====
// sgrr_divsqrt: shift-subtract unit, one quotient or root bit per cycle
// depends on sgrr_pkg (t_unit_cmd)

module sgrr_divsqrt import sgrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_unit_cmd   i_cmd,
    output logic        o_busy,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic        r_mode;
    logic [65:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_feed;
    logic [63:0] r_div;

    logic [65:0] n_rem;
    logic [63:0] n_quo;
    logic [65:0] rem2;
    logic [65:0] trial;
    logic        ge;

    always_comb begin
        if (r_mode) begin
            rem2  = {r_rem[63:0], r_feed[63:62]};
            trial = {r_quo, 2'b01};
        end else begin
            rem2  = {r_rem[64:0], r_feed[63]};
            trial = {2'b00, r_div};
        end
        ge    = (rem2 >= trial);
        n_rem = ge ? (rem2 - trial) : rem2;
        n_quo = {r_quo[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_cmd.sqrt_mode;
            r_rem  <= i_cmd.rem_init;
            r_quo  <= '0;
            r_feed <= i_cmd.feed;
            r_div  <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_feed <= r_mode ? {r_feed[61:0], 2'b00} : {r_feed[62:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== src/saturated_gyro_rate_recovery.sv =====
// saturated_gyro_rate_recovery: top level, sequencer and apb register file
// depends on sgrr_pkg, sgrr_mult, sgrr_divsqrt
//
// Use: one imu sample (gyro x/y/z, accel x/y/z, q16.16) enters as a request on the
// input channel (i_in_valid, o_in_stall); one corrected sample leaves on the output
// channel (o_out_valid, i_out_stall) with rates, the handled axis and a confidence tag.
// The block holds o_in_stall high from the cycle after a request is taken until the
// result has been moved into the output register, so one sample is in work at a time.
// Every multiply goes through one shared 32x32 multiplier with a registered product and
// every divide and square root through one shift-subtract unit, one bit per cycle.
// When no axis is saturated a sample takes three multiplies, a norm root and three
// divides, and a zero vector goes out after the root; when an axis is rebuilt, lever
// arithmetic, a q32 divide, the squares of the other axes and a root come first, and
// the divide is skipped when that quotient saturates; a rejected sample goes straight
// to the output. The next request is taken once the result is loaded and the block
// is idle again.
// While the receiver stalls, the result waits in the output register; the next sample
// may be taken meanwhile but finishes only once that register is free.
// Reset (synchronous, active low) clears both channels, loads the register defaults
// and sets the spin axis to (0, 0, 1). Registers are written over apb at 4*index.

module saturated_gyro_rate_recovery import sgrr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_gyro_x,
    input  logic signed [31:0] i_gyro_y,
    input  logic signed [31:0] i_gyro_z,
    input  logic signed [31:0] i_accel_x,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_rate_x,
    output logic signed [31:0] o_rate_y,
    output logic signed [31:0] o_rate_z,
    output logic [1:0]         o_fixed_axis,
    output logic [1:0]         o_confidence,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // configuration
    logic [LIMIT_W-1:0]        r_limit;
    logic signed [LEVER_W-1:0] r_lever [3];

    // control
    t_state r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_ph, n_ph;
    logic       r_first, n_first;
    logic       r_out_valid, n_out_valid;
    logic signed [AXIS_W-1:0] r_axis [3];
    logic signed [AXIS_W-1:0] n_axis [3];

    // sample payload and intermediates
    logic signed [31:0] r_gyro [3];
    logic signed [31:0] r_accel [3];
    logic signed [31:0] r_rate [3];
    logic signed [31:0] n_rate [3];
    logic signed [LEV_W-1:0] r_lev [3];
    logic signed [LEV_W-1:0] n_lev [3];
    logic signed [D_W-1:0] r_d, n_d;
    logic signed [63:0] r_acc, n_acc;
    logic [63:0] r_den, n_den;
    logic [63:0] r_w2, n_w2;
    logic [31:0] r_n, n_n;
    logic [1:0]  r_sat, n_sat;
    logic [1:0]  r_conf, n_conf;

    logic signed [31:0] r_o_rate [3];
    logic [1:0] r_o_axis, r_o_conf;

    logic in_accept;
    logic load_out;
    logic [1:0] in_sat;
    logic [1:0] ix;
    logic [1:0] sat_ix;

    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_prod;
    t_unit_cmd u_cmd;
    logic u_busy;
    logic [63:0] u_quo;

    logic signed [63:0] dsum;
    logic signed [63:0] dshift;
    logic signed [63:0] levw;
    logic [31:0] meas;
    logic [31:0] root;
    logic [31:0] mfix;
    logic [31:0] rmag;
    logic [17:0] q;

    sgrr_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (m_a),
        .i_b    (m_b),
        .o_prod (m_prod)
    );

    sgrr_divsqrt u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_cmd),
        .o_busy  (u_busy),
        .o_quo   (u_quo)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign ix         = r_idx[1:0];
    assign sat_ix     = r_sat - 2'd1;
    assign rmag       = mag32(r_rate[ix]);

    // first saturated axis in x, y, z order
    always_comb begin
        if (mag32(i_gyro_x) > {1'b0, r_limit}) begin
            in_sat = AXIS_X;
        end else if (mag32(i_gyro_y) > {1'b0, r_limit}) begin
            in_sat = AXIS_Y;
        end else if (mag32(i_gyro_z) > {1'b0, r_limit}) begin
            in_sat = AXIS_Z;
        end else begin
            in_sat = AXIS_NONE;
        end
    end

    // multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_DOT: begin
                m_a = {{(32-LEVER_W){r_lever[ix][LEVER_W-1]}}, r_lever[ix]};
                m_b = {{(32-AXIS_W){r_axis[ix][AXIS_W-1]}}, r_axis[ix]};
            end
            S_LEV: begin
                m_a = {{(32-D_W){r_d[D_W-1]}}, r_d};
                m_b = {{(32-AXIS_W){r_axis[ix][AXIS_W-1]}}, r_axis[ix]};
            end
            S_NUM: begin
                m_a = {{(32-LEV_W){r_lev[r_idx[2:1]][LEV_W-1]}}, r_lev[r_idx[2:1]]};
                if (r_idx[0]) begin
                    m_b = m_a;
                end else begin
                    m_b = r_accel[r_idx[2:1]];
                end
            end
            S_OTH: begin
                // the saturated axis itself contributes nothing
                if (ix != sat_ix) begin
                    m_a = r_gyro[ix];
                    m_b = r_gyro[ix];
                end
            end
            S_NSQ: begin
                m_a = r_rate[ix];
                m_b = r_rate[ix];
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // shift-subtract unit requests
    always_comb begin
        u_cmd = '0;
        if (r_first) begin
            unique case (r_state)
                S_DIV: begin
                    u_cmd.start     = 1'b1;
                    u_cmd.sqrt_mode = 1'b0;
                    u_cmd.iters     = ITER_W2;
                    u_cmd.rem_init  = {34'd0, r_acc[63:32]};
                    u_cmd.feed      = {r_acc[31:0], 32'd0};
                    u_cmd.divisor   = r_den;
                end
                S_ROOT: begin
                    u_cmd.start     = 1'b1;
                    u_cmd.sqrt_mode = 1'b1;
                    u_cmd.iters     = ITER_ROOT;
                    u_cmd.feed      = r_w2 - $unsigned(r_acc);
                end
                S_NRT: begin
                    u_cmd.start     = 1'b1;
                    u_cmd.sqrt_mode = 1'b1;
                    u_cmd.iters     = ITER_ROOT;
                    u_cmd.feed      = $unsigned(r_acc);
                end
                S_NDIV: begin
                    u_cmd.start     = 1'b1;
                    u_cmd.sqrt_mode = 1'b0;
                    u_cmd.iters     = ITER_NORM;
                    u_cmd.rem_init  = {35'd0, rmag[31:1]};
                    u_cmd.feed      = {rmag[0], 63'd0};
                    u_cmd.divisor   = {32'd0, r_n};
                end
                default: begin
                    u_cmd = '0;
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ph        = r_ph;
        n_first     = r_first;
        n_axis      = r_axis;
        n_rate      = r_rate;
        n_lev       = r_lev;
        n_d         = r_d;
        n_acc       = r_acc;
        n_den       = r_den;
        n_w2        = r_w2;
        n_n         = r_n;
        n_sat       = r_sat;
        n_conf      = r_conf;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        dsum   = r_acc + m_prod;
        dshift = dsum >>> 16;
        levw   = (m_prod >>> 16)
               - $signed({{(64-LEVER_W){r_lever[ix][LEVER_W-1]}}, r_lever[ix]});
        meas   = mag32(r_gyro[sat_ix]);
        root   = u_quo[31:0];
        mfix   = (root < meas) ? meas : root;
        q      = u_quo[17:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_rate[0] = i_gyro_x;
                    n_rate[1] = i_gyro_y;
                    n_rate[2] = i_gyro_z;
                    n_sat     = in_sat;
                    n_conf    = CONF_MEASURED;
                    n_idx     = '0;
                    n_ph      = 1'b0;
                    n_acc     = '0;
                    n_state   = (in_sat == AXIS_NONE) ? S_NSQ : S_DOT;
                end
            end
            S_DOT: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = dsum;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        n_d     = dshift[D_W-1:0];
                        n_idx   = '0;
                        n_state = S_LEV;
                    end
                end
            end
            S_LEV: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph      = 1'b0;
                    n_lev[ix] = levw[LEV_W-1:0];
                    n_idx     = r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        n_idx   = '0;
                        n_acc   = '0;
                        n_den   = '0;
                        n_state = S_NUM;
                    end
                end
            end
            S_NUM: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_idx[0]) begin
                        n_den = r_den + $unsigned(m_prod);
                    end else begin
                        n_acc = dsum;
                    end
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd5) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_idx = '0;
                if (r_den == 64'd0 || r_acc <= 64'sd0) begin
                    n_conf  = CONF_REJECT;
                    n_state = S_OUT;
                end else if ({32'd0, r_acc} >= {r_den, 32'd0}) begin
                    // integer part of the quotient too large
                    n_w2    = '1;
                    n_acc   = '0;
                    n_state = S_OTH;
                end else begin
                    n_first = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_first) begin
                    n_first = 1'b0;
                end else if (!u_busy) begin
                    n_w2    = u_quo;
                    n_acc   = '0;
                    n_idx   = '0;
                    n_state = S_OTH;
                end
            end
            S_OTH: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = dsum;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (r_w2 > $unsigned(r_acc)) begin
                    n_first = 1'b1;
                    n_state = S_ROOT;
                end else begin
                    n_conf  = CONF_REJECT;
                    n_state = S_OUT;
                end
            end
            S_ROOT: begin
                if (r_first) begin
                    n_first = 1'b0;
                end else if (!u_busy) begin
                    if (r_gyro[sat_ix][31]) begin
                        n_rate[sat_ix] = (mfix > 32'h8000_0000) ? 32'sh8000_0000
                                                               : $signed(32'd0 - mfix);
                    end else begin
                        n_rate[sat_ix] = (mfix > 32'h7fff_ffff) ? 32'sh7fff_ffff
                                                               : $signed(mfix);
                    end
                    n_conf  = CONF_RECON;
                    n_acc   = '0;
                    n_idx   = '0;
                    n_state = S_NSQ;
                end
            end
            S_NSQ: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = dsum;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        n_first = 1'b1;
                        n_state = S_NRT;
                    end
                end
            end
            S_NRT: begin
                if (r_first) begin
                    n_first = 1'b0;
                end else if (!u_busy) begin
                    n_n   = u_quo[31:0];
                    n_idx = '0;
                    if (u_quo[31:0] == 32'd0) begin
                        n_axis[0] = '0;
                        n_axis[1] = '0;
                        n_axis[2] = '0;
                        n_state   = S_OUT;
                    end else begin
                        n_first = 1'b1;
                        n_state = S_NDIV;
                    end
                end
            end
            S_NDIV: begin
                if (r_first) begin
                    n_first = 1'b0;
                end else if (!u_busy) begin
                    n_axis[ix] = r_rate[ix][31] ? $signed(18'd0 - q) : $signed(q);
                    if (r_idx == 3'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_first = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_ph        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
            r_axis[0]   <= '0;
            r_axis[1]   <= '0;
            r_axis[2]   <= AXIS_ONE;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ph        <= n_ph;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            r_axis      <= n_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gyro[0]  <= i_gyro_x;
            r_gyro[1]  <= i_gyro_y;
            r_gyro[2]  <= i_gyro_z;
            r_accel[0] <= i_accel_x;
            r_accel[1] <= i_accel_y;
            r_accel[2] <= i_accel_z;
        end
        r_rate <= n_rate;
        r_lev  <= n_lev;
        r_d    <= n_d;
        r_acc  <= n_acc;
        r_den  <= n_den;
        r_w2   <= n_w2;
        r_n    <= n_n;
        r_sat  <= n_sat;
        r_conf <= n_conf;
        if (load_out) begin
            r_o_rate <= r_rate;
            r_o_axis <= r_sat;
            r_o_conf <= r_conf;
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_lever[0] <= LEVER_X_RESET;
            r_lever[1] <= LEVER_Y_RESET;
            r_lever[2] <= LEVER_Z_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_LIMIT:   r_limit    <= pwdata[LIMIT_W-1:0];
                REG_LEVER_X: r_lever[0] <= pwdata[LEVER_W-1:0];
                REG_LEVER_Y: r_lever[1] <= pwdata[LEVER_W-1:0];
                REG_LEVER_Z: r_lever[2] <= pwdata[LEVER_W-1:0];
                default:     r_limit    <= r_limit;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LIMIT:   prdata = {1'b0, r_limit};
            REG_LEVER_X: prdata = {{(32-LEVER_W){r_lever[0][LEVER_W-1]}}, r_lever[0]};
            REG_LEVER_Y: prdata = {{(32-LEVER_W){r_lever[1][LEVER_W-1]}}, r_lever[1]};
            REG_LEVER_Z: prdata = {{(32-LEVER_W){r_lever[2][LEVER_W-1]}}, r_lever[2]};
            default:     prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_rate_x     = r_o_rate[0];
    assign o_rate_y     = r_o_rate[1];
    assign o_rate_z     = r_o_rate[2];
    assign o_fixed_axis = r_o_axis;
    assign o_confidence = r_o_conf;

endmodule

// ===== tb/sv/tb_saturated_gyro_rate_recovery.sv =====
// tb_saturated_gyro_rate_recovery: self-checking bench for the gyro rate recovery block
// drives imu samples and apb writes, predicts each result and compares field by field
// depends on sgrr_pkg and the top level saturated_gyro_rate_recovery
`timescale 1ns / 100ps

module tb_saturated_gyro_rate_recovery;
    import sgrr_pkg::*;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic [1:0]         axis;
        logic [1:0]         conf;
    } t_rate_out;

    typedef struct {
        logic signed [31:0] g [3];
        logic signed [31:0] a [3];
        bit                 has_exp;
        t_rate_out          exp_out;
    } t_sample_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    logic signed [31:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_rate_x, o_rate_y, o_rate_z;
    logic [1:0] o_fixed_axis, o_confidence;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    saturated_gyro_rate_recovery dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    longint unsigned pred_limit;
    longint pred_lever [3];
    longint pred_spin [3];

    t_rate_out rate_queue [$];
    int mismatch_count = 0;
    bit calm = 1'b0;        // no idling during this stretch

    function automatic longint fshift16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned div_q32(longint unsigned n, longint unsigned d);
        longint unsigned qi, r, frac;
        qi = n / d;
        r = n % d;
        frac = 0;
        if (qi >= (64'd1 << 32)) return '1;
        for (int i = 0; i < 32; i++) begin
            r <<= 1;
            frac <<= 1;
            if (r >= d) begin
                r -= d;
                frac |= 1;
            end
        end
        return (qi << 32) | frac;
    endfunction

    function automatic t_rate_out predict_rates(logic signed [31:0] g [3],
                                                logic signed [31:0] a [3]);
        longint rate [3], lev [3];
        longint d, num, den;
        longint unsigned w2, others, m, meas, n2, n, q;
        int sat;
        logic [1:0] conf;
        t_rate_out r;
        d = 0; num = 0; den = 0; sat = -1; conf = CONF_MEASURED;
        for (int i = 0; i < 3; i++) rate[i] = g[i];
        for (int i = 0; i < 3; i++)
            if (sat < 0 && mag(g[i]) > pred_limit) sat = i;
        if (sat >= 0) begin
            for (int i = 0; i < 3; i++) d += pred_lever[i] * pred_spin[i];
            d = fshift16(d);
            for (int i = 0; i < 3; i++) begin
                lev[i] = fshift16(d * pred_spin[i]) - pred_lever[i];
                num += lev[i] * longint'(a[i]);
                den += lev[i] * lev[i];
            end
            conf = CONF_REJECT;
            if (den > 0 && num > 0) begin
                w2 = div_q32(num, den);
                others = 0;
                for (int i = 0; i < 3; i++)
                    if (i != sat) others += mag(g[i]) * mag(g[i]);
                if (w2 > others) begin
                    m = isqrt(w2 - others);
                    meas = mag(g[sat]);
                    if (m < meas) m = meas;
                    if (g[sat] < 0) begin
                        if (m > (64'd1 << 31)) m = 64'd1 << 31;
                        rate[sat] = -longint'(m);
                    end else begin
                        if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
                        rate[sat] = longint'(m);
                    end
                    conf = CONF_RECON;
                end
            end
        end
        if (conf != CONF_REJECT) begin
            n2 = 0;
            for (int i = 0; i < 3; i++) n2 += mag(rate[i]) * mag(rate[i]);
            n = isqrt(n2);
            for (int i = 0; i < 3; i++) begin
                if (n == 0) begin
                    pred_spin[i] = 0;
                end else begin
                    q = (mag(rate[i]) << 16) / n;
                    pred_spin[i] = rate[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
        r.rx = rate[0][31:0];
        r.ry = rate[1][31:0];
        r.rz = rate[2][31:0];
        r.axis = 2'(sat + 1);
        r.conf = conf;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // output side: random stall, check on accept
    always @(posedge i_clk) begin
        t_rate_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rate_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = rate_queue.pop_front();
                if (o_rate_x !== e.rx) report_mismatch("rate_x", o_rate_x, e.rx);
                if (o_rate_y !== e.ry) report_mismatch("rate_y", o_rate_y, e.ry);
                if (o_rate_z !== e.rz) report_mismatch("rate_z", o_rate_z, e.rz);
                if (o_fixed_axis !== e.axis)
                    report_mismatch("fixed_axis", o_fixed_axis, e.axis);
                if (o_confidence !== e.conf)
                    report_mismatch("confidence", o_confidence, e.conf);
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
    end

    task automatic reg_write(logic [1:0] idx, longint value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_LIMIT) pred_limit = value & 64'h7FFFFFFF;
        else pred_lever[idx - 1] = $signed(value[LEVER_W-1:0]);
    endtask

    // waits for queue to drain, then lets the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (rate_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_sample(logic signed [31:0] g [3], logic signed [31:0] a [3],
                               bit chk, t_rate_out want);
        t_rate_out p;
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_gyro_x <= g[0]; i_gyro_y <= g[1]; i_gyro_z <= g[2];
        i_accel_x <= a[0]; i_accel_y <= a[1]; i_accel_z <= a[2];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_rates(g, a);
        if (chk && p !== want)
            report_mismatch("predictor row", longint'(p.conf), longint'(want.conf));
        rate_queue.insert(rate_queue.size(), p);
    endtask

    function automatic logic signed [31:0] rand_word(int limit_hint);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return $signed($urandom_range(2 * limit_hint)) - limit_hint;
            default: return $signed($urandom_range(4 * limit_hint)) - 2 * limit_hint;
        endcase
    endfunction

    initial begin
        t_sample_row rows [$];
        t_sample_row row;
        t_rate_out none;
        logic signed [31:0] g [3], a [3];
        int hint;
        pred_limit = LIMIT_RESET;
        pred_lever[0] = LEVER_X_RESET; pred_lever[1] = LEVER_Y_RESET;
        pred_lever[2] = LEVER_Z_RESET;
        pred_spin[0] = 0; pred_spin[1] = 0; pred_spin[2] = AXIS_ONE;
        none = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: zero, extremes, each axis saturated, rejects, recoveries
        row.has_exp = 1'b1;
        row.g = '{0, 0, 0}; row.a = '{0, 0, 0};
        row.exp_out = '{0, 0, 0, AXIS_NONE, CONF_MEASURED}; rows.insert(rows.size(), row);
        row.g = '{65536, -65536, 0}; row.a = '{0, 0, 0};
        row.exp_out = '{65536, -65536, 0, AXIS_NONE, CONF_MEASURED};
        rows.insert(rows.size(), row);
        row.g = '{32'sh7FFFFFFF, 0, 0}; row.a = '{0, 0, 0};
        row.exp_out = '{32'sh7FFFFFFF, 0, 0, AXIS_X, CONF_REJECT};
        rows.insert(rows.size(), row);
        row.g = '{0, 32'sh80000000, 0}; row.a = '{0, 0, 0};
        row.exp_out = '{0, 32'sh80000000, 0, AXIS_Y, CONF_REJECT};
        rows.insert(rows.size(), row);
        row.g = '{0, 0, 786433}; row.a = '{0, 0, 0};
        row.exp_out = '{0, 0, 786433, AXIS_Z, CONF_REJECT}; rows.insert(rows.size(), row);
        row.g = '{0, 0, 786432}; row.a = '{0, 0, 0};
        row.exp_out = '{0, 0, 786432, AXIS_NONE, CONF_MEASURED};
        rows.insert(rows.size(), row);
        row.has_exp = 1'b0;
        row.g = '{900000, 1000, -2000}; row.a = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
        rows.insert(rows.size(), row);
        row.g = '{-900000, 0, 0}; row.a = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
        rows.insert(rows.size(), row);
        row.g = '{0, 2000000, 5}; row.a = '{-300000, -900000, 500000};
        rows.insert(rows.size(), row);
        row.g = '{0, 0, -1000000}; row.a = '{3000000, 4000000, -2000000};
        rows.insert(rows.size(), row);
        row.g = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        row.a = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}; rows.insert(rows.size(), row);
        row.g = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        row.a = '{32'sh80000000, 32'sh80000000, 32'sh80000000}; rows.insert(rows.size(), row);
        row.g = '{100, 200, 300}; row.a = '{0, 0, 0}; rows.insert(rows.size(), row);
        foreach (rows[i]) send_sample(rows[i].g, rows[i].a, rows[i].has_exp,
                                      rows[i].has_exp ? rows[i].exp_out : none);
        drain_results();

        // lever along current axis gives zero lever length
        reg_write(REG_LEVER_X, 0); reg_write(REG_LEVER_Y, 0); reg_write(REG_LEVER_Z, 0);
        g = '{0, 0, 900000}; a = '{100000, 100000, 100000};
        send_sample(g, a, 1'b0, none);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_LIMIT, 64'h7FFFFFFF);
                    reg_write(REG_LEVER_X, 131072); reg_write(REG_LEVER_Y, -131072);
                    reg_write(REG_LEVER_Z, 131072);
                end
                1: begin
                    reg_write(REG_LIMIT, 0);
                    reg_write(REG_LEVER_X, -131072); reg_write(REG_LEVER_Y, 131072);
                    reg_write(REG_LEVER_Z, -131072);
                end
                2: begin
                    reg_write(REG_LIMIT, LIMIT_RESET);
                    reg_write(REG_LEVER_X, LEVER_X_RESET); reg_write(REG_LEVER_Y, LEVER_Y_RESET);
                    reg_write(REG_LEVER_Z, LEVER_Z_RESET);
                end
                default: begin
                    reg_write(REG_LIMIT, $urandom_range(3000000));
                    reg_write(REG_LEVER_X, $signed($urandom_range(262144)) - 131072);
                    reg_write(REG_LEVER_Y, $signed($urandom_range(262144)) - 131072);
                    reg_write(REG_LEVER_Z, $signed($urandom_range(262144)) - 131072);
                end
            endcase
            calm = (phase == 3);
            hint = (pred_limit > 64'd4000000) ? 4000000 : int'(pred_limit) + 1;
            for (int k = 0; k < 125; k++) begin
                for (int i = 0; i < 3; i++) begin
                    g[i] = rand_word(hint);
                    a[i] = ($urandom_range(3) == 0) ? $urandom
                                                    : $signed($urandom_range(8000000)) - 4000000;
                end
                send_sample(g, a, 1'b0, none);
                // sender holds off until every result is back
                if (k == 60) begin
                    i_in_valid <= 1'b0;
                    while (rate_queue.size() != 0) @(posedge i_clk);
                end
            end
            calm = 1'b0;
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
